/* rtl/rgb_to_hsv_assert.svh */
// Assertion macros used by the checker file of the colour converter.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef RGB_TO_HSV_ASSERT_SVH
`define RGB_TO_HSV_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define R2H_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define R2H_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/r2h_pkg.sv */
`default_nettype none

package r2h_pkg;

  // Widths of the pixel and result fields.
  localparam int CH_W  = 8;
  localparam int HUE_W = 9;
  localparam int PCT_W = 7;

  // Pipelined divider: dividend, divisor and quotient widths.
  localparam int DIV_DW = 9;
  localparam int DIV_QW = 9;
  localparam int DIV_NW = DIV_DW + DIV_QW;

  // Front stages, one stage per quotient bit, and the output stage.
  localparam int FRONT_STAGES = 2;
  localparam int PIPE_STAGES  = FRONT_STAGES + DIV_QW + 1;

  // Arithmetic constants.
  localparam logic [HUE_W-1:0]  HUE_FULL  = HUE_W'(360);
  localparam logic [DIV_NW-1:0] PCT_SCALE = DIV_NW'(200);

  // Brightness by reciprocal multiplication: (mx * VAL_MUL + VAL_RND) >> VAL_SHIFT
  // equals mx * 100 / 255 rounded to nearest for every eight-bit mx.
  localparam int                VAL_PW    = 32;
  localparam int                VAL_SHIFT = 24;
  localparam logic [VAL_PW-1:0] VAL_MUL   = VAL_PW'(6579400);
  localparam logic [VAL_PW-1:0] VAL_RND   = VAL_PW'(8388735);

  // Which channel holds the maximum.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } r2h_sector_e;

  // Side information and the finished brightness that travel alongside the quotients.
  typedef struct packed {
    logic             hue_neg;
    logic             grey;
    logic             black;
    logic [PCT_W-1:0] val;
  } r2h_tag_t;

endpackage

`default_nettype wire

/* rtl/rgb_to_hsv.sv */
// Channel  | Direction | Handshake           | Payload
// pixel    | in        | valid_i / ready_o   | red_i, green_i, blue_i (8 bits each)
// result   | out       | valid_o / ready_i   | hue_o (9), saturation_o (7), brightness_o (7)
//
// One pixel is accepted per cycle while ready_o is high; its result is offered after
// passing through twelve register stages: two front stages, nine divider
// stages (one quotient bit each) and the output register.
// The number of divider stages is set by the nine-bit quotient of the hue and saturation divider lanes.
// Reset clears the valid bits of every stage; payload registers are not reset.
// A stall at the output stops only the stages behind occupied ones, so bubbles close
// up and nothing is lost or repeated.
`default_nettype none

module rgb_to_hsv import r2h_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [CH_W-1:0]  red_i,
  input  wire logic [CH_W-1:0]  green_i,
  input  wire logic [CH_W-1:0]  blue_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic      [HUE_W-1:0] hue_o,
  output logic      [PCT_W-1:0] saturation_o,
  output logic      [PCT_W-1:0] brightness_o
);

  logic [PIPE_STAGES-1:0] v_d, v_q;
  logic [PIPE_STAGES:0]   rdy;

  logic [DIV_NW-1:0] hue_num, sat_num;
  logic [DIV_DW-1:0] hue_den, sat_den;
  logic [DIV_QW-1:0] hue_quo, sat_quo;
  logic [DIV_QW-1:0] div_en;
  r2h_tag_t          front_tag;
  r2h_tag_t          tag_q [DIV_QW];

  logic [HUE_W-1:0] hue_d, hue_q;
  logic [PCT_W-1:0] sat_d, sat_q, val_d, val_q;

  // A stage takes a new item when it is empty or its own item moves on.
  always_comb begin
    rdy[PIPE_STAGES] = ready_i;
    for (int s = PIPE_STAGES - 1; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
    v_d[0] = rdy[0] ? valid_i : v_q[0];
    for (int s = 1; s < PIPE_STAGES; s++) begin
      v_d[s] = rdy[s] ? v_q[s-1] : v_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign ready_o = rdy[0];
  assign div_en  = rdy[FRONT_STAGES +: DIV_QW];

  // Sector, spread and dividend set-up.
  r2h_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (rdy[FRONT_STAGES-1:0]),
    .red_i     (red_i),
    .green_i   (green_i),
    .blue_i    (blue_i),
    .hue_num_o (hue_num),
    .hue_den_o (hue_den),
    .sat_num_o (sat_num),
    .sat_den_o (sat_den),
    .tag_o     (front_tag)
  );

  // Two divider lanes advancing in step.
  r2h_div u_hue_div (
    .clk_i (clk_i),
    .en_i  (div_en),
    .num_i (hue_num),
    .den_i (hue_den),
    .quo_o (hue_quo)
  );

  r2h_div u_sat_div (
    .clk_i (clk_i),
    .en_i  (div_en),
    .num_i (sat_num),
    .den_i (sat_den),
    .quo_o (sat_quo)
  );

  // The special-case flags and the brightness follow their item through the divider.
  for (genvar s = 0; s < DIV_QW; s++) begin : g_tag
    always_ff @(posedge clk_i) begin
      if (div_en[s]) begin
        tag_q[s] <= (s == 0) ? front_tag : tag_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  // Negative red-sector hues wrap round; grey and black pixels give zero.
  always_comb begin
    if (tag_q[DIV_QW-1].grey) begin
      hue_d = '0;
    end else if (tag_q[DIV_QW-1].hue_neg && hue_quo != '0) begin
      hue_d = HUE_FULL - HUE_W'(hue_quo);
    end else begin
      hue_d = HUE_W'(hue_quo);
    end
    sat_d = tag_q[DIV_QW-1].black ? '0 : sat_quo[PCT_W-1:0];
    val_d = tag_q[DIV_QW-1].val;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[PIPE_STAGES-1]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= val_d;
    end
  end

  assign valid_o      = v_q[PIPE_STAGES-1];
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = val_q;

endmodule

`default_nettype wire

/* rtl/r2h_front.sv */
`default_nettype none

module r2h_front import r2h_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [FRONT_STAGES-1:0] en_i,
  input  wire logic [CH_W-1:0]         red_i,
  input  wire logic [CH_W-1:0]         green_i,
  input  wire logic [CH_W-1:0]         blue_i,
  output logic      [DIV_NW-1:0]       hue_num_o,
  output logic      [DIV_DW-1:0]       hue_den_o,
  output logic      [DIV_NW-1:0]       sat_num_o,
  output logic      [DIV_DW-1:0]       sat_den_o,
  output r2h_tag_t                     tag_o
);

  logic [CH_W-1:0] mx_d, mx_q, delta_d, delta_q, mag_d, mag_q, mn;
  logic            neg_d, neg_q;
  r2h_sector_e     sector_d, sector_q;
  logic [CH_W:0]   diff;

  logic [DIV_NW-2:0] term60, base_term, num;
  logic [DIV_NW-1:0] hue_num_d, sat_num_d;
  logic [DIV_DW-1:0] hue_den_d, sat_den_d;
  logic [VAL_PW-1:0] val_prod;
  r2h_tag_t          tag_d;

  // Stage A: maximum channel with red winning ties, then green; minimum and spread.
  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      sector_d = SEC_RED;
      mx_d     = red_i;
      diff     = {1'b0, green_i} - {1'b0, blue_i};
    end else if (green_i >= blue_i) begin
      sector_d = SEC_GREEN;
      mx_d     = green_i;
      diff     = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      sector_d = SEC_BLUE;
      mx_d     = blue_i;
      diff     = {1'b0, red_i} - {1'b0, green_i};
    end
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    delta_d = mx_d - mn;
    neg_d   = diff[CH_W];
    mag_d   = neg_d ? CH_W'(-diff) : diff[CH_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mx_q     <= mx_d;
      delta_q  <= delta_d;
      mag_q    <= mag_d;
      neg_q    <= neg_d;
      sector_q <= sector_d;
    end
  end

  // Stage B: the hue numerator is the sector base times the spread plus or minus
  // sixty times the channel difference; every quotient is set up for rounding.
  // Brightness is finished here by a reciprocal multiplication.
  always_comb begin
    term60 = (DIV_NW-1)'(mag_q) * (DIV_NW-1)'(60);
    unique case (sector_q)
      SEC_GREEN: base_term = (DIV_NW-1)'(delta_q) * (DIV_NW-1)'(120);
      SEC_BLUE:  base_term = (DIV_NW-1)'(delta_q) * (DIV_NW-1)'(240);
      default:   base_term = '0;
    endcase
    if (sector_q == SEC_RED) begin
      num = term60;
    end else if (neg_q) begin
      num = base_term - term60;
    end else begin
      num = base_term + term60;
    end
    hue_num_d = {num, 1'b0} + DIV_NW'(delta_q);
    hue_den_d = {delta_q, 1'b0};
    sat_num_d = DIV_NW'(delta_q) * PCT_SCALE + DIV_NW'(mx_q);
    sat_den_d = {mx_q, 1'b0};
    val_prod  = VAL_PW'(mx_q) * VAL_MUL + VAL_RND;
    tag_d.hue_neg = (sector_q == SEC_RED) && neg_q;
    tag_d.grey    = (delta_q == '0);
    tag_d.black   = (mx_q == '0);
    tag_d.val     = val_prod[VAL_SHIFT +: PCT_W];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      hue_num_o <= hue_num_d;
      hue_den_o <= hue_den_d;
      sat_num_o <= sat_num_d;
      sat_den_o <= sat_den_d;
      tag_o     <= tag_d;
    end
  end

  // The front stages hold payload only; the reset is used by the valid chain in rgb_to_hsv.
  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

`default_nettype wire

/* rtl/r2h_div.sv */
`default_nettype none

module r2h_div import r2h_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic [DIV_QW-1:0] en_i,
  input  wire logic [DIV_NW-1:0] num_i,
  input  wire logic [DIV_DW-1:0] den_i,
  output logic      [DIV_QW-1:0] quo_o
);

  logic [DIV_NW-1:0] rem_q [DIV_QW];
  logic [DIV_DW-1:0] den_q [DIV_QW];
  logic [DIV_QW-1:0] quo_q [DIV_QW];

  // One restoring step per stage, most significant quotient bit first.
  for (genvar s = 0; s < DIV_QW; s++) begin : g_stage
    localparam int Bit = DIV_QW - 1 - s;

    logic [DIV_NW-1:0] rem_in, shifted;
    logic [DIV_DW-1:0] den_in;
    logic [DIV_QW-1:0] quo_in, quo_bit;
    logic              fit;

    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign shifted = DIV_NW'(den_in) << Bit;
    assign fit     = (rem_in >= shifted);
    assign quo_bit = DIV_QW'(fit) << Bit;

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= fit ? rem_in - shifted : rem_in;
        den_q[s] <= den_in;
        quo_q[s] <= quo_in | quo_bit;
      end
    end
  end

  assign quo_o = quo_q[DIV_QW-1];

endmodule

`default_nettype wire

/* rtl/r2h_checker.sv */
`default_nettype none

`include "rgb_to_hsv_assert.svh"

module r2h_checker import r2h_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             valid_i,
  input wire logic             ready_o,
  input wire logic [CH_W-1:0]  red_i,
  input wire logic [CH_W-1:0]  green_i,
  input wire logic [CH_W-1:0]  blue_i,
  input wire logic             valid_o,
  input wire logic             ready_i,
  input wire logic [HUE_W-1:0] hue_o,
  input wire logic [PCT_W-1:0] saturation_o,
  input wire logic [PCT_W-1:0] brightness_o
);

  // Input side is observed only for completeness of the bound port list.
  logic unused_in;
  assign unused_in = valid_i ^ (^red_i) ^ (^green_i) ^ (^blue_i);

  // A result that is held back stays and keeps its payload.
  `R2H_ASSERT_NEXT(a_out_hold, valid_o && !ready_i, valid_o && $stable(hue_o) && $stable(saturation_o) && $stable(brightness_o), "result changed while stalled")

  // Hue is always a whole angle below a full turn.
  `R2H_ASSERT_NOW(a_hue_range, valid_o, hue_o < HUE_FULL, "hue out of range")

  // Percentages never exceed one hundred.
  `R2H_ASSERT_NOW(a_pct_range, valid_o, saturation_o <= PCT_W'(100) && brightness_o <= PCT_W'(100), "percentage out of range")

  // The input is only held off while a result waits at a stalled output.
  `R2H_ASSERT_NOW(a_stall_cause, !ready_o, valid_o && !ready_i, "input stalled with room")

endmodule

bind rgb_to_hsv r2h_checker u_r2h_checker (.*);

`default_nettype wire
